>>> rtl/core/eldt_pkg.sv
// shared types and constants for the edge list degree tracker
package eldt_pkg;

    localparam int VID_W    = 10;
    localparam int CNT_W    = 13;
    localparam int STATUS_W = 2;
    localparam int EDGE_W   = 2 * VID_W + CNT_W;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0]    DEG_SAT = 13'h1FFF;
    localparam logic [VID_W-1:0]    VCOUNT_RST = 10'd1023;
    localparam logic [CNT_W-1:0]    ELIMIT_RST = 13'd4096;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIMIT   = 1'd1;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_CLEAR = 5'b01000,
        ST_REPLY = 5'b10000
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic rd_en;
        logic sweep_init;
        logic sweep_wr;
        logic sweep_full;
        logic commit;
        logic reply;
    } ctrl_cmd_t;

    typedef struct packed {
        logic action;
        logic sweep_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/eldt_ram.sv
// generic single write port ram with registered read
module eldt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/eldt_ctrl.sv
// controller state machine for the edge list degree tracker
module eldt_ctrl
    import eldt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                // zero the vertex stores after reset
                cmd.sweep_wr   = 1'b1;
                cmd.sweep_full = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.latch_in   = in_valid;
                cmd.sweep_init = in_valid;
                if (in_valid)
                begin
                    state_next = stat.action ? ST_CLEAR : ST_ADD;
                end
            end
            ST_ADD:
            begin
                // read data is held until the output slot frees up
                cmd.commit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                cmd.reply = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

>>> rtl/core/eldt_dp.sv
// datapath: vertex and edge stores, counters, checks and output register
module eldt_dp
    import eldt_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 action,
    input  logic [VID_W-1:0]     src,
    input  logic [VID_W-1:0]     dst,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [CNT_W-1:0]     edge_index,
    output logic [CNT_W-1:0]     next_edge,
    output logic [CNT_W-1:0]     in_degree_dst,
    output logic [CNT_W-1:0]     out_degree_src,
    output logic [CNT_W-1:0]     max_in_degree,
    output logic [CNT_W-1:0]     max_out_degree
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [VAW-1:0] VTOP_MAX = VAW'(MAX_VERTICES - 1);

    function automatic logic [VAW-1:0] to_vaddr(input logic [VID_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[VAW-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] d);
        return (d == DEG_SAT) ? d : d + 1'b1;
    endfunction

    function automatic logic id_ok(input logic [VID_W-1:0] v,
                                   input logic [VID_W-1:0] top);
        return (v <= top) && (32'(v) < MAX_VERTICES);
    endfunction

    logic [VID_W-1:0]    vcount_reg;
    logic [CNT_W-1:0]    elimit_reg;
    logic [VID_W-1:0]    src_reg;
    logic [VID_W-1:0]    dst_reg;
    logic [CNT_W-1:0]    edge_cnt_reg;
    logic [CNT_W-1:0]    edge_cnt_next;
    logic [CNT_W-1:0]    max_in_reg;
    logic [CNT_W-1:0]    max_in_next;
    logic [CNT_W-1:0]    max_out_reg;
    logic [CNT_W-1:0]    max_out_next;
    logic [VAW-1:0]      sweep_cnt_reg;
    logic [VAW-1:0]      sweep_cnt_next;
    logic [VAW-1:0]      vtop;
    logic [VAW-1:0]      sweep_top;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    edge_index_reg;
    logic [CNT_W-1:0]    next_edge_reg;
    logic [CNT_W-1:0]    in_deg_reg;
    logic [CNT_W-1:0]    out_deg_reg;
    logic [CNT_W-1:0]    max_in_out_reg;
    logic [CNT_W-1:0]    max_out_out_reg;

    logic [2*CNT_W-1:0]  hs_rd_data;
    logic [CNT_W-1:0]    in_rd_data;
    logic [CNT_W-1:0]    prev_head;
    logic [CNT_W-1:0]    out_new;
    logic [CNT_W-1:0]    in_new;
    logic [CNT_W-1:0]    slot;
    logic                range_ok;
    logic                full;
    logic                add_ok;
    logic                add_wr;
    logic                load;
    logic [VAW-1:0]      hs_wr_addr;
    logic [VAW-1:0]      in_wr_addr;
    logic [2*CNT_W-1:0]  hs_wr_data;
    logic [CNT_W-1:0]    in_wr_data;
    logic [31:0]         edge_addr_wide;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RST;
            elimit_reg <= ELIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VERTEX_COUNT: vcount_reg <= cfg_data[VID_W-1:0];
                REG_EDGE_LIMIT:   elimit_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            src_reg <= src;
            dst_reg <= dst;
        end
    end

    // checks and update values
    assign prev_head = hs_rd_data[2*CNT_W-1:CNT_W];
    assign out_new   = bump(hs_rd_data[CNT_W-1:0]);
    assign in_new    = bump(in_rd_data);
    assign slot      = edge_cnt_reg + 1'b1;
    assign range_ok  = id_ok(src_reg, vcount_reg) && id_ok(dst_reg, vcount_reg);
    assign full      = (edge_cnt_reg >= elimit_reg) || (32'(edge_cnt_reg) >= MAX_EDGES);
    assign add_ok    = range_ok && !full;
    assign add_wr    = cmd.commit && add_ok;
    assign load      = cmd.commit || cmd.reply;

    // clear range capped at the store depth
    assign vtop      = (32'(vcount_reg) > MAX_VERTICES - 1) ? VTOP_MAX
                                                            : to_vaddr(vcount_reg);
    assign sweep_top = cmd.sweep_full ? VTOP_MAX : vtop;

    assign hs_wr_addr = cmd.sweep_wr ? sweep_cnt_reg : to_vaddr(src_reg);
    assign in_wr_addr = cmd.sweep_wr ? sweep_cnt_reg : to_vaddr(dst_reg);
    assign hs_wr_data = cmd.sweep_wr ? '0 : {slot, out_new};
    assign in_wr_data = cmd.sweep_wr ? '0 : in_new;
    assign edge_addr_wide = 32'(edge_cnt_reg);

    always_comb
    begin
        edge_cnt_next  = edge_cnt_reg;
        max_in_next    = max_in_reg;
        max_out_next   = max_out_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (add_wr)
        begin
            edge_cnt_next = slot;
            max_in_next   = (in_new > max_in_reg) ? in_new : max_in_reg;
            max_out_next  = (out_new > max_out_reg) ? out_new : max_out_reg;
        end
        else if (cmd.reply)
        begin
            edge_cnt_next = '0;
            max_in_next   = '0;
            max_out_next  = '0;
        end
        if (cmd.sweep_init)
        begin
            sweep_cnt_next = '0;
        end
        else if (cmd.sweep_wr)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_cnt_reg  <= '0;
            max_in_reg    <= '0;
            max_out_reg   <= '0;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            edge_cnt_reg  <= edge_cnt_next;
            max_in_reg    <= max_in_next;
            max_out_reg   <= max_out_next;
            sweep_cnt_reg <= sweep_cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg      <= STATUS_OK;
            edge_index_reg  <= '0;
            next_edge_reg   <= '0;
            in_deg_reg      <= '0;
            out_deg_reg     <= '0;
            max_in_out_reg  <= max_in_next;
            max_out_out_reg <= max_out_next;
            if (cmd.commit)
            begin
                if (!range_ok)
                begin
                    status_reg <= STATUS_RANGE;
                end
                else if (full)
                begin
                    status_reg <= STATUS_FULL;
                end
                else
                begin
                    edge_index_reg <= slot;
                    next_edge_reg  <= prev_head;
                    in_deg_reg     <= in_new;
                    out_deg_reg    <= out_new;
                end
            end
        end
    end

    // head and out-degree share an address, so they share a ram
    eldt_ram #(
        .WIDTH (2 * CNT_W),
        .DEPTH (MAX_VERTICES)
    ) u_head_out_ram (
        .clk     (clk),
        .wr_en   (add_wr || cmd.sweep_wr),
        .wr_addr (hs_wr_addr),
        .wr_data (hs_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (to_vaddr(src)),
        .rd_data (hs_rd_data)
    );

    eldt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_VERTICES)
    ) u_in_ram (
        .clk     (clk),
        .wr_en   (add_wr || cmd.sweep_wr),
        .wr_addr (in_wr_addr),
        .wr_data (in_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (to_vaddr(dst)),
        .rd_data (in_rd_data)
    );

    // edge slots are written only
    eldt_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (add_wr),
        .wr_addr (edge_addr_wide[EAW-1:0]),
        .wr_data ({src_reg, dst_reg, prev_head}),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    assign stat.action     = action;
    assign stat.sweep_last = (sweep_cnt_reg == sweep_top);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign edge_index     = edge_index_reg;
    assign next_edge      = next_edge_reg;
    assign in_degree_dst  = in_deg_reg;
    assign out_degree_src = out_deg_reg;
    assign max_in_degree  = max_in_out_reg;
    assign max_out_degree = max_out_out_reg;

endmodule

>>> rtl/core/edge_list_degree_tracker_top.sv
// top level of the edge list degree tracker
// add: accepted in idle, where the head/degree rams are read; in the add state
//   they are written, result registered when output frees; one add at a time
// clear: one vertex per cycle, up to vertex_count (capped at MAX_VERTICES-1)
// reset: async active low; then a sweep zeroes every entry of the vertex rams
//   while in_ready stays low (config writes still taken)
module edge_list_degree_tracker_top
    import eldt_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [VID_W-1:0]     src,
    input  logic [VID_W-1:0]     dst,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [CNT_W-1:0]     edge_index,
    output logic [CNT_W-1:0]     next_edge,
    output logic [CNT_W-1:0]     in_degree_dst,
    output logic [CNT_W-1:0]     out_degree_src,
    output logic [CNT_W-1:0]     max_in_degree,
    output logic [CNT_W-1:0]     max_out_degree
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    eldt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    eldt_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .src            (src),
        .dst            (dst),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .edge_index     (edge_index),
        .next_edge      (next_edge),
        .in_degree_dst  (in_degree_dst),
        .out_degree_src (out_degree_src),
        .max_in_degree  (max_in_degree),
        .max_out_degree (max_out_degree)
    );

endmodule

>>> rtl/core/eldt_checker.sv
// port level checks for the edge list degree tracker, bound to the top level
module eldt_checker
    import eldt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [CNT_W-1:0]    edge_index,
    input logic [CNT_W-1:0]    next_edge,
    input logic [CNT_W-1:0]    in_degree_dst,
    input logic [CNT_W-1:0]    out_degree_src,
    input logic [CNT_W-1:0]    max_in_degree,
    input logic [CNT_W-1:0]    max_out_degree
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(edge_index) && $stable(max_in_degree))
        else $error("result changed while stalled");

    // refused adds give no slot and no degrees
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> edge_index == '0 && next_edge == '0
            && in_degree_dst == '0 && out_degree_src == '0)
        else $error("refused add carries data");

    // a granted slot always comes with nonzero degrees no larger than the maxima
    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && edge_index != '0 |-> in_degree_dst != '0 && out_degree_src != '0
            && max_in_degree >= in_degree_dst && max_out_degree >= out_degree_src)
        else $error("degree above running maximum");

endmodule

bind edge_list_degree_tracker_top eldt_checker u_eldt_checker (.*);
